>>> rtl/mhe_pkg.sv
// ----------------------------------------------------------------------------
// MessagePack header encoder package
// Shared codes, sizes and the token entry type used between the front end,
// the token queue and the byte serializer.
// ----------------------------------------------------------------------------
package mhe_pkg;

  // Request function codes.
  typedef enum logic [3:0] {
    FUNC_NIL   = 4'd0,
    FUNC_BOOL  = 4'd1,
    FUNC_SINT  = 4'd2,
    FUNC_UINT  = 4'd3,
    FUNC_F32   = 4'd4,
    FUNC_F64   = 4'd5,
    FUNC_STR   = 4'd6,
    FUNC_BIN   = 4'd7,
    FUNC_ARRAY = 4'd8,
    FUNC_MAP   = 4'd9,
    FUNC_EXT   = 4'd10
  } func_e;

  // Longest token in bytes: prefix plus eight data bytes.
  localparam int unsigned MaxBytes = 9;
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);
  localparam int unsigned BufW     = 8 * MaxBytes;

  // Token queue depth.
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // MessagePack format codes.
  localparam logic [7:0] CodeNil     = 8'hc0;
  localparam logic [7:0] CodeFalse   = 8'hc2;
  localparam logic [7:0] CodeTrue    = 8'hc3;
  localparam logic [7:0] CodeBin8    = 8'hc4;
  localparam logic [7:0] CodeBin16   = 8'hc5;
  localparam logic [7:0] CodeBin32   = 8'hc6;
  localparam logic [7:0] CodeExt8    = 8'hc7;
  localparam logic [7:0] CodeExt16   = 8'hc8;
  localparam logic [7:0] CodeExt32   = 8'hc9;
  localparam logic [7:0] CodeFloat32 = 8'hca;
  localparam logic [7:0] CodeFloat64 = 8'hcb;
  localparam logic [7:0] CodeUint8   = 8'hcc;
  localparam logic [7:0] CodeUint16  = 8'hcd;
  localparam logic [7:0] CodeUint32  = 8'hce;
  localparam logic [7:0] CodeUint64  = 8'hcf;
  localparam logic [7:0] CodeInt8    = 8'hd0;
  localparam logic [7:0] CodeInt16   = 8'hd1;
  localparam logic [7:0] CodeInt32   = 8'hd2;
  localparam logic [7:0] CodeInt64   = 8'hd3;
  localparam logic [7:0] CodeFixExt1 = 8'hd4;
  localparam logic [7:0] CodeFixExt2 = 8'hd5;
  localparam logic [7:0] CodeFixExt4 = 8'hd6;
  localparam logic [7:0] CodeFixExt8 = 8'hd7;
  localparam logic [7:0] CodeFixExt16 = 8'hd8;
  localparam logic [7:0] CodeStr8    = 8'hd9;
  localparam logic [7:0] CodeStr16   = 8'hda;
  localparam logic [7:0] CodeArr16   = 8'hdc;
  localparam logic [7:0] CodeMap16   = 8'hde;
  localparam logic [7:0] FixStrBase  = 8'ha0;
  localparam logic [7:0] FixArrBase  = 8'h90;
  localparam logic [7:0] FixMapBase  = 8'h80;

  // One classified token: bytes in stream order, first byte in the top bits.
  typedef struct packed {
    logic [BufW-1:0] bytes;
    logic [CntW-1:0] count;
  } entry_t;

endpackage

>>> rtl/mhe_front.sv
// ----------------------------------------------------------------------------
// MessagePack header encoder front end
// Holds the compatibility register and turns each accepted request into a
// packed byte string for the token queue.
// ----------------------------------------------------------------------------
module mhe_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 accept_i,
  input  logic [3:0]           func_i,
  input  logic [63:0]          value_i,
  input  logic signed [7:0]    ext_type_i,
  output logic                 push_o,
  output mhe_pkg::entry_t      entry_o
);
  import mhe_pkg::*;

  logic        compat_q, compat_d;
  logic [7:0]  hdr;
  logic [3:0]  dsize;
  logic        ext;
  logic        known;
  logic [31:0] len;
  logic [63:0] v;

  assign v   = value_i;
  assign len = value_i[31:0];

  always_comb begin
    compat_d = cfg_we_i ? cfg_wdata_i : compat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compat_q <= 1'b0;
    end else begin
      compat_q <= compat_d;
    end
  end

  // Classification: prefix byte, number of big-endian data bytes, and
  // whether the extension type byte follows.
  always_comb begin
    hdr   = CodeNil;
    dsize = 4'd0;
    ext   = 1'b0;
    known = 1'b1;
    case (func_e'(func_i))
      FUNC_NIL: begin
        hdr = CodeNil;
      end
      FUNC_BOOL: begin
        hdr = v[0] ? CodeTrue : CodeFalse;
      end
      FUNC_SINT, FUNC_UINT: begin
        if (v[63:32] == 32'd0) begin
          if (len <= 32'd127) begin
            hdr = len[7:0];
          end else if (len <= 32'hff) begin
            hdr = CodeUint8;   dsize = 4'd1;
          end else if (len <= 32'hffff) begin
            hdr = CodeUint16;  dsize = 4'd2;
          end else begin
            hdr = CodeUint32;  dsize = 4'd4;
          end
        end else if (func_e'(func_i) == FUNC_UINT) begin
          hdr = CodeUint64; dsize = 4'd8;
        end else if (!v[63]) begin
          hdr = CodeInt64; dsize = 4'd8;
        end else if (&v[63:5]) begin
          // Negative fixint.
          hdr = v[7:0];
        end else if (&v[63:7]) begin
          hdr = CodeInt8;  dsize = 4'd1;
        end else if (&v[63:15]) begin
          hdr = CodeInt16; dsize = 4'd2;
        end else if (&v[63:31]) begin
          hdr = CodeInt32; dsize = 4'd4;
        end else begin
          hdr = CodeInt64; dsize = 4'd8;
        end
      end
      FUNC_F32: begin
        hdr = CodeFloat32; dsize = 4'd4;
      end
      FUNC_F64: begin
        hdr = CodeFloat64; dsize = 4'd8;
      end
      FUNC_STR, FUNC_BIN: begin
        if (func_e'(func_i) == FUNC_BIN && !compat_q) begin
          if (len <= 32'hff) begin
            hdr = CodeBin8;  dsize = 4'd1;
          end else if (len <= 32'hffff) begin
            hdr = CodeBin16; dsize = 4'd2;
          end else begin
            hdr = CodeBin32; dsize = 4'd4;
          end
        end else if (len <= 32'd31) begin
          hdr = FixStrBase | len[7:0];
        end else if (len <= 32'hff && !compat_q) begin
          // Only strings reach here outside compatibility mode.
          hdr = CodeStr8; dsize = 4'd1;
        end else if (len <= 32'hffff) begin
          hdr = CodeStr16; dsize = 4'd2;
        end else begin
          hdr = CodeStr16 + 8'd1; dsize = 4'd4;
        end
      end
      FUNC_ARRAY, FUNC_MAP: begin
        if (len <= 32'd15) begin
          hdr = ((func_e'(func_i) == FUNC_ARRAY) ? FixArrBase : FixMapBase) | len[7:0];
        end else if (len <= 32'hffff) begin
          hdr = (func_e'(func_i) == FUNC_ARRAY) ? CodeArr16 : CodeMap16;
          dsize = 4'd2;
        end else begin
          hdr = ((func_e'(func_i) == FUNC_ARRAY) ? CodeArr16 : CodeMap16) + 8'd1;
          dsize = 4'd4;
        end
      end
      FUNC_EXT: begin
        ext = 1'b1;
        if (len == 32'd1) begin
          hdr = CodeFixExt1;
        end else if (len == 32'd2) begin
          hdr = CodeFixExt2;
        end else if (len == 32'd4) begin
          hdr = CodeFixExt4;
        end else if (len == 32'd8) begin
          hdr = CodeFixExt8;
        end else if (len == 32'd16) begin
          hdr = CodeFixExt16;
        end else if (len <= 32'hff) begin
          hdr = CodeExt8;  dsize = 4'd1;
        end else if (len <= 32'hffff) begin
          hdr = CodeExt16; dsize = 4'd2;
        end else begin
          hdr = CodeExt32; dsize = 4'd4;
        end
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Pack prefix, data bytes and the optional type byte, first byte on top.
  always_comb begin
    entry_o.bytes = {hdr, 64'd0};
    case (dsize)
      4'd1:    entry_o.bytes[63:56] = v[7:0];
      4'd2:    entry_o.bytes[63:48] = v[15:0];
      4'd4:    entry_o.bytes[63:32] = v[31:0];
      4'd8:    entry_o.bytes[63:0]  = v;
      default: ;
    endcase
    if (ext) begin
      case (dsize)
        4'd0:    entry_o.bytes[63:56] = $unsigned(ext_type_i);
        4'd1:    entry_o.bytes[55:48] = $unsigned(ext_type_i);
        4'd2:    entry_o.bytes[47:40] = $unsigned(ext_type_i);
        default: entry_o.bytes[31:24] = $unsigned(ext_type_i);
      endcase
    end
    entry_o.count = CntW'(4'd1 + dsize + {3'd0, ext});
  end

  assign push_o = accept_i && known;

endmodule

>>> rtl/mhe_queue.sv
// ----------------------------------------------------------------------------
// MessagePack header encoder token queue
// Small register FIFO between the front end and the byte serializer.
// ----------------------------------------------------------------------------
module mhe_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mhe_pkg::entry_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output mhe_pkg::entry_t pop_data_o,
  output logic            empty_o
);
  import mhe_pkg::*;

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ((wr_q == QPtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop_i  ? ((rd_q == QPtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/mhe_back.sv
// ----------------------------------------------------------------------------
// MessagePack header encoder byte serializer
// Loads one token from the queue and shifts it out one byte per cycle.
// ----------------------------------------------------------------------------
module mhe_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  mhe_pkg::entry_t entry_i,
  output logic            pop_o,
  output logic            out_strobe_o,
  output logic [7:0]      out_byte_o,
  output logic            last_o
);
  import mhe_pkg::*;

  logic [BufW-1:0] sh_q, sh_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // A new token is loaded in the cycle that shows the last byte of the
  // previous one, so bytes leave without gaps.
  assign pop_o = !empty_i && (cnt_q <= CntW'(1));

  always_comb begin
    sh_d  = sh_q;
    cnt_d = cnt_q;
    if (pop_o) begin
      sh_d  = entry_i.bytes;
      cnt_d = entry_i.count;
    end else if (cnt_q != '0) begin
      sh_d  = {sh_q[BufW-9:0], 8'd0};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign out_strobe_o = (cnt_q != '0);
  assign out_byte_o   = sh_q[BufW-1 -: 8];
  assign last_o       = (cnt_q == CntW'(1));

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxBytes))
    else $error("serializer byte count out of range");

  a_token_contiguous : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !last_o) |=> out_strobe_o)
    else $error("token bytes not contiguous");

  a_no_load_midtoken : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (!out_strobe_o || last_o))
    else $error("token loaded while previous token still shifting");

endmodule

>>> rtl/msgpack_header_encoder.sv
// ----------------------------------------------------------------------------
// MessagePack header encoder
// Encodes one MessagePack token request per start into its big-endian byte
// string, one byte per cycle, the final byte flagged by last_o.
// ----------------------------------------------------------------------------
// Usage:
//   A request (func_i, value_i, ext_type_i) is taken at a rising edge where
//   start is high and busy is low. Requests with an unknown func code are
//   taken and dropped without any output.
//   Each encoded byte shows on out_byte_o for exactly one cycle with
//   out_strobe_o high; last_o marks the final byte of the token. The receiver
//   cannot stall the byte stream, so it must take every strobed byte.
//   A token is 1 to 9 bytes long and leaves at one byte per cycle while
//   the queue holds tokens; the serializer loads the next token while the
//   last byte of the previous one shows. When the serializer is idle, a taken
//   request is written to the queue and then loaded before its first byte.
//   A two-entry token queue sits between the classifier and the serializer,
//   so requests are taken while earlier tokens are still going out; busy is
//   high only while that queue is full.
//   cfg_we_i writes compat_mode from cfg_wdata_i; write it only while no
//   token is pending. Reset clears compat_mode, empties the queue and stops
//   the serializer.
// ----------------------------------------------------------------------------
module msgpack_header_encoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              start,
  output logic              busy,
  input  logic [3:0]        func_i,
  input  logic [63:0]       value_i,
  input  logic signed [7:0] ext_type_i,
  output logic              out_strobe_o,
  output logic [7:0]        out_byte_o,
  output logic              last_o
);
  import mhe_pkg::*;

  logic   accept;
  logic   push;
  logic   full;
  logic   pop;
  logic   empty;
  entry_t push_entry;
  entry_t pop_entry;

  // A request is taken whenever the queue has room.
  assign busy   = full;
  assign accept = start && !full;

  // Front end: compatibility register and request classification.
  mhe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .func_i      (func_i),
    .value_i     (value_i),
    .ext_type_i  (ext_type_i),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  // Token queue decouples classification from byte output.
  mhe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .empty_o     (empty)
  );

  // Back end: shifts each token out a byte per cycle.
  mhe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .entry_i      (pop_entry),
    .pop_o        (pop),
    .out_strobe_o (out_strobe_o),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o)
  );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MessagePack header encoder testbench
// Sends token requests of every kind through the encoder, predicts the byte
// stream of each accepted request and checks every strobed byte and its last
// flag in order. Both compat_mode settings are covered, with idle gaps,
// back-to-back bursts and queue-full stalls.
// ----------------------------------------------------------------------------
module tb;
  import mhe_pkg::*;

  // Watchdog limit, far above the slowest correct run: roughly 160 requests
  // of nine bytes each plus the longest idle gaps and the drain pauses around
  // the configuration writes.
  localparam int unsigned CycleLimit = 200000;
  // Cycles allowed for the token queue and serializer to settle before a
  // configuration write and at the end of the run.
  localparam int unsigned DrainCycles = 12;
  // Function codes that the encoder takes and drops without output.
  localparam logic [3:0] FuncUnusedLo = 4'd11;
  localparam logic [3:0] FuncUnusedHi = 4'd15;

  // One predicted output byte.
  typedef struct {
    logic [7:0] data;
    logic       last;
  } enc_byte_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_wdata_i = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  logic [3:0]        func_i      = 4'd0;
  logic [63:0]       value_i     = '0;
  logic signed [7:0] ext_type_i  = '0;
  logic              out_strobe_o;
  logic [7:0]        out_byte_o;
  logic              last_o;

  // Predictor state: our own copy of compat_mode, the bytes of the token
  // being encoded and the stream of bytes still owed by the encoder.
  logic       compat_pred = 1'b0;
  logic [7:0] token_bytes [$];
  enc_byte_t  pending_bytes [$];
  enc_byte_t  want;

  int fail_count = 0;
  int n_sent     = 0;
  int n_dropped  = 0;
  int n_checked  = 0;
  int cycles     = 0;

  msgpack_header_encoder uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start       (start),
    .busy        (busy),
    .func_i      (func_i),
    .value_i     (value_i),
    .ext_type_i  (ext_type_i),
    .out_strobe_o(out_strobe_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost byte ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d bytes still pending", cycles,
               pending_bytes.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor. Each function appends to token_bytes, most significant byte
  // first, the way the encoder serializes a token.
  // ---------------------------------------------------------------------------
  function automatic void add_byte(logic [7:0] b);
    token_bytes.insert(token_bytes.size(), b);
  endfunction

  function automatic void put_be(logic [63:0] v, int nbytes);
    for (int k = nbytes - 1; k >= 0; k--) add_byte(v[8*k +: 8]);
  endfunction

  function automatic void put_prefixed(logic [7:0] code, logic [63:0] v, int nbytes);
    add_byte(code);
    put_be(v, nbytes);
  endfunction

  // Smallest unsigned form for values that fit in 32 bits.
  function automatic void enc_uint32(logic [63:0] v);
    if (v <= 64'd127) add_byte(v[7:0]);
    else if (v <= 64'hff) put_prefixed(CodeUint8, v, 1);
    else if (v <= 64'hffff) put_prefixed(CodeUint16, v, 2);
    else put_prefixed(CodeUint32, v, 4);
  endfunction

  // Fix form up to fix_max, then the 16-bit code, then the 32-bit code that
  // always directly follows it in the code space.
  function automatic void enc_len3(logic [63:0] len, logic [7:0] fix_base,
                                   logic [63:0] fix_max, logic [7:0] code16);
    if (len <= fix_max) add_byte(fix_base | len[7:0]);
    else if (len <= 64'hffff) put_prefixed(code16, len, 2);
    else put_prefixed(code16 + 8'd1, len, 4);
  endfunction

  // Encodes one accepted request and queues its bytes as expectations.
  function automatic void encode_token(logic [3:0] f, logic [63:0] v, logic [7:0] t);
    logic [63:0] len;
    len = {32'd0, v[31:0]};
    token_bytes.delete();
    case (f)
      FUNC_NIL:   add_byte(CodeNil);
      FUNC_BOOL:  add_byte(v[0] ? CodeTrue : CodeFalse);
      FUNC_SINT: begin
        // Nonnegative values share the unsigned forms up to 32 bits; all
        // wider signed values go out as int64.
        if (!v[63]) begin
          if (v <= 64'hffff_ffff) enc_uint32(v);
          else put_prefixed(CodeInt64, v, 8);
        end else if (v >= 64'hffff_ffff_ffff_ffe0) add_byte(v[7:0]);
        else if (v >= 64'hffff_ffff_ffff_ff80) put_prefixed(CodeInt8, v, 1);
        else if (v >= 64'hffff_ffff_ffff_8000) put_prefixed(CodeInt16, v, 2);
        else if (v >= 64'hffff_ffff_8000_0000) put_prefixed(CodeInt32, v, 4);
        else put_prefixed(CodeInt64, v, 8);
      end
      FUNC_UINT: begin
        if (v <= 64'hffff_ffff) enc_uint32(v);
        else put_prefixed(CodeUint64, v, 8);
      end
      FUNC_F32:   put_prefixed(CodeFloat32, len, 4);
      FUNC_F64:   put_prefixed(CodeFloat64, v, 8);
      FUNC_STR: begin
        // str8 does not exist in the old spec.
        if (len > 64'd31 && len <= 64'hff && !compat_pred) put_prefixed(CodeStr8, len, 1);
        else enc_len3(len, FixStrBase, 64'd31, CodeStr16);
      end
      FUNC_BIN: begin
        // Old decoders only know raw strings, so binary headers reuse them.
        if (compat_pred) enc_len3(len, FixStrBase, 64'd31, CodeStr16);
        else if (len <= 64'hff) put_prefixed(CodeBin8, len, 1);
        else if (len <= 64'hffff) put_prefixed(CodeBin16, len, 2);
        else put_prefixed(CodeBin32, len, 4);
      end
      FUNC_ARRAY: enc_len3(len, FixArrBase, 64'd15, CodeArr16);
      FUNC_MAP:   enc_len3(len, FixMapBase, 64'd15, CodeMap16);
      FUNC_EXT: begin
        case (len)
          64'd1:   add_byte(CodeFixExt1);
          64'd2:   add_byte(CodeFixExt2);
          64'd4:   add_byte(CodeFixExt4);
          64'd8:   add_byte(CodeFixExt8);
          64'd16:  add_byte(CodeFixExt16);
          default: begin
            if (len <= 64'hff) put_prefixed(CodeExt8, len, 1);
            else if (len <= 64'hffff) put_prefixed(CodeExt16, len, 2);
            else put_prefixed(CodeExt32, len, 4);
          end
        endcase
        add_byte(t);
      end
      default: ;
    endcase
    foreach (token_bytes[i]) begin
      pending_bytes.insert(pending_bytes.size(),
                           '{data: token_bytes[i], last: (i == token_bytes.size() - 1)});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Sends one request and, when idling is allowed, may hold start low for a
  // random gap afterwards. Start stays high between back-to-back requests, so
  // it is never lowered and raised within one time step.
  task automatic send_request(input logic [3:0] f, input logic [63:0] v,
                              input logic [7:0] t, input bit idle_on);
    int gap;
    start      <= 1'b1;
    func_i     <= f;
    value_i    <= v;
    ext_type_i <= t;
    do @(posedge clk_i); while (busy);
    encode_token(f, v, t);
    n_sent++;
    if (token_bytes.size() == 0) n_dropped++;
    if (idle_on && $urandom_range(0, 2) != 0) begin
      // Mostly short gaps, now and then a long one.
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Waits until the encoder has nothing left to send, then writes the
  // compatibility register.
  task automatic set_compat(input logic mode);
    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    compat_pred = mode;
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [63:0] boundary(int idx);
    case (idx)
      0:       return 64'd16;
      1:       return 64'd32;
      2:       return 64'd128;
      3:       return 64'd256;
      4:       return 64'h1_0000;
      5:       return 64'h8000_0000;
      6:       return 64'h1_0000_0000;
      default: return 64'h8000_0000_0000_0000;
    endcase
  endfunction

  // Operand mix: fully random words, values within two of every form
  // boundary on both signs, fixext lengths and small values, the length
  // kinds often with junk in the upper half.
  function automatic logic [63:0] rand_operand();
    logic [63:0] near;
    near = boundary($urandom_range(0, 7)) + 64'($urandom_range(0, 4)) - 64'd2;
    case ($urandom_range(0, 5))
      0:       return {$urandom, $urandom};
      1:       return near;
      2:       return 64'd0 - near;
      3:       return {$urandom, 32'($urandom_range(0, 300))};
      4:       return {$urandom, 32'(1 << $urandom_range(0, 4))};
      default: return 64'($urandom_range(0, 300));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Every kind once or more with the current spec, at the edges of the forms.
  task automatic test_directed_forms();
    send_request(FUNC_NIL,   64'd0, 8'h00, 1'b1);
    send_request(FUNC_BOOL,  64'hffff_ffff_ffff_fffe, 8'h00, 1'b1);
    send_request(FUNC_BOOL,  64'd1, 8'h00, 1'b1);
    send_request(FUNC_SINT,  64'hffff_ffff_ffff_ffe0, 8'h00, 1'b1);
    send_request(FUNC_SINT,  64'hffff_ffff_ffff_ffdf, 8'h00, 1'b1);
    send_request(FUNC_SINT,  64'h8000_0000_0000_0000, 8'h00, 1'b1);
    send_request(FUNC_SINT,  64'h7fff_ffff_ffff_ffff, 8'h00, 1'b1);
    send_request(FUNC_SINT,  64'hffff_ffff_7fff_ffff, 8'h00, 1'b1);
    send_request(FUNC_UINT,  64'd127, 8'h00, 1'b0);
    send_request(FUNC_UINT,  64'd128, 8'h00, 1'b0);
    send_request(FUNC_UINT,  64'h1_0000, 8'h00, 1'b0);
    send_request(FUNC_UINT,  64'hffff_ffff_ffff_ffff, 8'h00, 1'b0);
    send_request(FUNC_F32,   64'hdead_beef_7f80_0000, 8'h00, 1'b1);
    send_request(FUNC_F64,   64'hffff_ffff_ffff_ffff, 8'h00, 1'b1);
    send_request(FUNC_STR,   64'd31, 8'h00, 1'b1);
    send_request(FUNC_STR,   64'd32, 8'h00, 1'b1);
    send_request(FUNC_STR,   64'hffff_ffff_0001_0000, 8'h00, 1'b1);
    send_request(FUNC_BIN,   64'd255, 8'h00, 1'b1);
    send_request(FUNC_BIN,   64'd256, 8'h00, 1'b1);
    send_request(FUNC_ARRAY, 64'd15, 8'h00, 1'b1);
    send_request(FUNC_ARRAY, 64'd16, 8'h00, 1'b1);
    send_request(FUNC_MAP,   64'h0000_0001_ffff_ffff, 8'h00, 1'b1);
    send_request(FUNC_EXT,   64'd1, 8'h80, 1'b1);
    send_request(FUNC_EXT,   64'd16, 8'h7f, 1'b1);
    send_request(FUNC_EXT,   64'd3, 8'($urandom), 1'b1);
    send_request(FUNC_EXT,   64'd70000, 8'($urandom), 1'b1);
    send_request(FuncUnusedHi, 64'hffff_ffff_ffff_ffff, 8'hff, 1'b1);
  endtask

  // The old spec: no str8, binary headers as raw strings, extensions as is.
  task automatic test_directed_compat();
    set_compat(1'b1);
    send_request(FUNC_STR, 64'd32, 8'h00, 1'b1);
    send_request(FUNC_STR, 64'd255, 8'h00, 1'b1);
    send_request(FUNC_BIN, 64'd0, 8'h00, 1'b1);
    send_request(FUNC_BIN, 64'd31, 8'h00, 1'b1);
    send_request(FUNC_BIN, 64'd32, 8'h00, 1'b1);
    send_request(FUNC_BIN, 64'h1_0000, 8'h00, 1'b1);
    send_request(FUNC_EXT, 64'd8, 8'h5a, 1'b1);
  endtask

  // Random requests with one compat setting; about one in ten carries an
  // unused function code.
  task automatic test_random_phase(input int count, input logic mode, input bit idle_on);
    logic [3:0] f;
    set_compat(mode);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) f = 4'($urandom_range(FuncUnusedLo, FuncUnusedHi));
      else f = 4'($urandom_range(FUNC_NIL, FUNC_EXT));
      send_request(f, rand_operand(), 8'($urandom), idle_on);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output checker: every strobed byte must match the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && out_strobe_o) begin
      n_checked++;
      if (pending_bytes.size() == 0) begin
        $error("out_byte: expected nothing, actual %02h (last %0b)", out_byte_o, last_o);
        fail_count++;
      end else begin
        want = pending_bytes[0];
        pending_bytes.delete(0);
        if (out_byte_o !== want.data) begin
          $error("out_byte: expected %02h, actual %02h", want.data, out_byte_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_forms();
    test_directed_compat();
    test_random_phase(40, 1'b0, 1'b1);
    test_random_phase(40, 1'b1, 1'b1);
    // Back-to-back requests keep the token queue full and busy toggling.
    test_random_phase(40, 1'b0, 1'b0);

    start <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d requests (%0d with unused codes), %0d output bytes checked.",
             n_sent, n_dropped, n_checked);
    $display("Both compat settings ran with idle gaps, bursts and queue-full stalls.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
